// ===== sv/fcpwm_pkg.sv =====
package fcpwm_pkg;

	localparam int NUM_CH  = 4;
	localparam int CNT_W   = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [1:0] {
		OP_TICK         = 2'd0,
		OP_WR_COMPARE   = 2'd1,
		OP_WR_RELOAD    = 2'd2,
		OP_FORCE_UPDATE = 2'd3
	} op_t;

	localparam logic [1:0] MODE_TOGGLE = 2'd0;
	localparam logic [1:0] MODE_PWM1   = 2'd1;
	localparam logic [1:0] MODE_PWM2   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_PRESCALE_DIV     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_MODE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ENABLE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_POLARITY = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_ENABLE   = 3'd4;

	typedef struct packed {
		op_t               op;
		logic [NUM_CH-1:0] channel_mask;
		logic [CNT_W-1:0]  value;
	} pwm_in_t;

	typedef struct packed {
		logic [NUM_CH-1:0] channel_out;
		logic [CNT_W-1:0]  count_now;
		logic              update_event;
		logic [NUM_CH-1:0] compare_match;
	} pwm_out_t;

endpackage

// ===== sv/four_channel_pwm_timer.sv =====
// Four-channel edge-aligned up-counting timer with output compare. Each accepted
// item is a tick, a compare write, a reload write or a forced update, and yields
// exactly one result carrying the channel levels, the counter value and the
// update and match flags. The block takes one item per clock cycle unless the
// result register is full and out_ready is low; each item passes through the
// input register and then the result register, and in_ready follows out_ready
// within the same cycle when both registers are full. The counter and compare
// update is combinational between those two registers.
module four_channel_pwm_timer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  fcpwm_pkg::pwm_in_t                    in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output fcpwm_pkg::pwm_out_t                   out_data,
	input  logic                                  cfg_write,
	input  logic [fcpwm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [fcpwm_pkg::CFG_W-1:0]           cfg_data
);
	import fcpwm_pkg::*;

	// Configuration registers.
	logic [CNT_W-1:0]  prescale_div_q;
	logic [1:0]        output_mode_q;
	logic [NUM_CH-1:0] channel_enable_q;
	logic [NUM_CH-1:0] channel_polarity_q;
	logic              counter_enable_q;

	// Timer state.
	logic [CNT_W-1:0]  prescale_count_q;
	logic [CNT_W-1:0]  main_count_q;
	logic [CNT_W-1:0]  reload_buf_q;
	logic [CNT_W-1:0]  reload_act_q;
	logic [CNT_W-1:0]  cmp_buf_q [NUM_CH];
	logic [CNT_W-1:0]  cmp_act_q [NUM_CH];
	logic [NUM_CH-1:0] toggle_q;

	// Pipeline.
	logic              valid_s1;
	pwm_in_t           item_s1;
	logic              out_valid_q;
	pwm_out_t          out_q;
	logic              step_s1;

	// Next-state values.
	logic [CNT_W-1:0]  prescale_count_d;
	logic [CNT_W-1:0]  main_count_d;
	logic [CNT_W-1:0]  reload_buf_d;
	logic [CNT_W-1:0]  reload_act_d;
	logic [CNT_W-1:0]  cmp_buf_d [NUM_CH];
	logic [CNT_W-1:0]  cmp_act_d [NUM_CH];
	logic [NUM_CH-1:0] toggle_d;
	logic              load_d;
	logic [NUM_CH-1:0] match_d;
	logic [NUM_CH-1:0] level_d;

	assign step_s1   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || step_s1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		logic advance;
		logic ref_lvl;
		logic below;
		prescale_count_d = prescale_count_q;
		main_count_d     = main_count_q;
		reload_buf_d     = reload_buf_q;
		toggle_d         = toggle_q;
		load_d           = 1'b0;
		match_d          = '0;
		advance          = 1'b0;
		for (int c = 0; c < NUM_CH; c++) begin
			cmp_buf_d[c] = cmp_buf_q[c];
		end
		unique case (item_s1.op)
			OP_TICK: begin
				if (counter_enable_q) begin
					if (prescale_count_q >= prescale_div_q) begin
						prescale_count_d = '0;
						advance          = 1'b1;
					end else begin
						prescale_count_d = prescale_count_q + 1'b1;
					end
				end
				if (advance) begin
					if (main_count_q >= reload_act_q) begin
						main_count_d = '0;
						load_d       = 1'b1;
					end else begin
						main_count_d = main_count_q + 1'b1;
					end
				end
			end
			OP_WR_COMPARE: begin
				for (int c = 0; c < NUM_CH; c++) begin
					if (item_s1.channel_mask[c]) begin
						cmp_buf_d[c] = item_s1.value;
					end
				end
			end
			OP_WR_RELOAD: begin
				reload_buf_d = item_s1.value;
			end
			OP_FORCE_UPDATE: begin
				main_count_d     = '0;
				prescale_count_d = '0;
				load_d           = 1'b1;
			end
			default: begin
			end
		endcase

		// On a wrap the freshly loaded compares are the ones checked at zero.
		reload_act_d = load_d ? reload_buf_q : reload_act_q;
		for (int c = 0; c < NUM_CH; c++) begin
			cmp_act_d[c] = load_d ? cmp_buf_q[c] : cmp_act_q[c];
		end

		for (int c = 0; c < NUM_CH; c++) begin
			if (advance && (main_count_d == cmp_act_d[c])) begin
				match_d[c] = 1'b1;
				if (output_mode_q == MODE_TOGGLE) begin
					toggle_d[c] = ~toggle_q[c];
				end
			end
		end

		for (int c = 0; c < NUM_CH; c++) begin
			below = main_count_d < cmp_act_d[c];
			unique case (output_mode_q)
				MODE_TOGGLE: ref_lvl = toggle_d[c];
				MODE_PWM1:   ref_lvl = below;
				MODE_PWM2:   ref_lvl = ~below;
				default:     ref_lvl = 1'b0;
			endcase
			level_d[c] = channel_enable_q[c] & (ref_lvl ^ channel_polarity_q[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_div_q     <= '0;
			output_mode_q      <= MODE_PWM1;
			channel_enable_q   <= '0;
			channel_polarity_q <= '0;
			counter_enable_q   <= 1'b0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_PRESCALE_DIV:     prescale_div_q     <= cfg_data[CNT_W-1:0];
				CFG_OUTPUT_MODE:      output_mode_q      <= cfg_data[1:0];
				CFG_CHANNEL_ENABLE:   channel_enable_q   <= cfg_data[NUM_CH-1:0];
				CFG_CHANNEL_POLARITY: channel_polarity_q <= cfg_data[NUM_CH-1:0];
				CFG_COUNTER_ENABLE:   counter_enable_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_count_q <= '0;
			main_count_q     <= '0;
			reload_buf_q     <= '1;
			reload_act_q     <= '1;
			toggle_q         <= '0;
			for (int c = 0; c < NUM_CH; c++) begin
				cmp_buf_q[c] <= '0;
				cmp_act_q[c] <= '0;
			end
		end else if (step_s1) begin
			prescale_count_q <= prescale_count_d;
			main_count_q     <= main_count_d;
			reload_buf_q     <= reload_buf_d;
			reload_act_q     <= reload_act_d;
			toggle_q         <= toggle_d;
			for (int c = 0; c < NUM_CH; c++) begin
				cmp_buf_q[c] <= cmp_buf_d[c];
				cmp_act_q[c] <= cmp_act_d[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (step_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (step_s1) begin
			out_q.channel_out   <= level_d;
			out_q.count_now     <= main_count_d;
			out_q.update_event  <= load_d;
			out_q.compare_match <= match_d;
		end
	end

endmodule
